>>> sv/greedy_knapsack_selector_core_assert.svh
// Assertion macros shared by the selector RTL
`ifndef GREEDY_KNAPSACK_SELECTOR_CORE_ASSERT_SVH
`define GREEDY_KNAPSACK_SELECTOR_CORE_ASSERT_SVH

// implication checked in the next cycle, outside reset
`define GKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication checked in the same cycle, outside reset
`define GKS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/gks_pkg.sv
// ---------------------------------------------------------------------------
// gks_pkg
// Shared constants and types of the greedy knapsack selector.
// ---------------------------------------------------------------------------
`default_nettype none
package gks_pkg;
  localparam int MAX_ITEMS = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int VAL_W     = 16;
  localparam int WGT_W     = 16;
  localparam int CAP_W     = 24;
  localparam int SUMV_W    = 22;
  localparam int PROD_W    = VAL_W + WGT_W;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_MUL,
    ST_SORT_CMP,
    ST_WALK_RDO,
    ST_WALK_RDI,
    ST_WALK_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } gks_state_t;
endpackage
`default_nettype wire

>>> sv/gks_density_cmp.sv
// ---------------------------------------------------------------------------
// gks_density_cmp
// Exact value-per-weight compare by registered cross products.
// ---------------------------------------------------------------------------
`default_nettype none
module gks_density_cmp import gks_pkg::*; (
  input  wire logic             clk,
  input  wire logic [VAL_W-1:0] cand_value,
  input  wire logic [WGT_W-1:0] cand_weight,
  input  wire logic [VAL_W-1:0] best_value,
  input  wire logic [WGT_W-1:0] best_weight,
  output logic                  cand_gt
);
  logic [PROD_W-1:0] left_r;
  logic [PROD_W-1:0] right_r;

  always_ff @(posedge clk) begin
    left_r  <= cand_value * best_weight;
    right_r <= best_value * cand_weight;
  end

  // valid in the cycle after the operands
  assign cand_gt = left_r > right_r;
endmodule
`default_nettype wire

>>> sv/greedy_knapsack_selector_core.sv
// ---------------------------------------------------------------------------
// greedy_knapsack_selector_core
// Greedy 0/1 knapsack by value density over a stored item set.
// ---------------------------------------------------------------------------
// Items load one per cycle into an item memory (up to MAX_ITEMS, extras are
// dropped). The transaction with last_item set starts the solve: a selection
// sort over the memory, with a read, the cross products and a compare for
// each unranked candidate and a read alone for each candidate already ranked;
// a greedy walk that reads the order, then the item, then checks it; then n
// results in load order, each read, loaded and held until taken. No input is
// taken from the last item until the last result is taken. The item memory
// has a single read port, so each of these steps makes its own read.
`default_nettype none
module greedy_knapsack_selector_core import gks_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CAP_W-1:0]  cfg_knapsack_capacity,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [VAL_W-1:0]  in_item_value,
  input  wire logic [WGT_W-1:0]  in_item_weight,
  input  wire logic              in_item_allowed,
  input  wire logic              in_last_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IDX_W:0]         out_item_index,
  output logic                   out_item_chosen,
  output logic [CAP_W-1:0]       out_total_weight,
  output logic [SUMV_W-1:0]      out_total_value,
  output logic                   out_last_result
);
  localparam int ITEM_W = 1 + WGT_W + VAL_W;

  gks_state_t state_r, state_nxt;

  logic [CAP_W-1:0]     cap_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     i_r;
  logic [CNT_W-1:0]     pos_r;
  logic [MAX_ITEMS-1:0] used_r;
  logic [MAX_ITEMS-1:0] chosen_r;
  logic                 best_none_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [VAL_W-1:0]     best_v_r;
  logic [WGT_W-1:0]     best_w_r;
  logic [IDX_W-1:0]     k_r;
  logic [CAP_W-1:0]     filled_r;
  logic [CAP_W-1:0]     sum_w_r;
  logic [SUMV_W-1:0]    sum_v_r;
  logic                 out_valid_r;

  logic [ITEM_W-1:0] item_mem [MAX_ITEMS];
  logic [IDX_W-1:0]  order_mem [MAX_ITEMS];
  logic [ITEM_W-1:0] item_rd_r;
  logic [IDX_W-1:0]  order_rd_r;
  logic [IDX_W-1:0]  item_addr;

  logic             in_fire, out_fire, cmp_gt, i_last, pos_last;
  logic [VAL_W-1:0] rd_v;
  logic [WGT_W-1:0] rd_w;
  logic             rd_a;
  logic [CAP_W:0]   fill_try;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign rd_v     = item_rd_r[VAL_W-1:0];
  assign rd_w     = item_rd_r[VAL_W +: WGT_W];
  assign rd_a     = item_rd_r[ITEM_W-1];
  assign i_last   = (i_r + 1'b1) == n_r;
  assign pos_last = (pos_r + 1'b1) == n_r;
  assign fill_try = {1'b0, filled_r} + {{(CAP_W+1-WGT_W){1'b0}}, rd_w};

  gks_density_cmp u_cmp (
    .clk         (clk),
    .cand_value  (rd_v),
    .cand_weight (rd_w),
    .best_value  (best_v_r),
    .best_weight (best_w_r),
    .cand_gt     (cmp_gt)
  );

  // outputs and read address
  always_comb begin
    in_ready  = state_r == ST_LOAD;
    cfg_ready = 1'b1;
    out_valid = out_valid_r;
    unique case (state_r)
      ST_WALK_RDI: item_addr = order_rd_r;
      ST_WALK_CHK: item_addr = k_r;
      default:     item_addr = i_r[IDX_W-1:0];
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:     if (in_fire && in_last_item) state_nxt = ST_SORT_RD;
      ST_SORT_RD: begin
        if (!used_r[i_r[IDX_W-1:0]]) begin
          state_nxt = ST_SORT_MUL;
        end else if (i_last && pos_last) begin
          state_nxt = ST_WALK_RDO;
        end
      end
      ST_SORT_MUL: state_nxt = ST_SORT_CMP;
      ST_SORT_CMP: state_nxt = (i_last && pos_last) ? ST_WALK_RDO : ST_SORT_RD;
      ST_WALK_RDO: state_nxt = ST_WALK_RDI;
      ST_WALK_RDI: state_nxt = ST_WALK_CHK;
      ST_WALK_CHK: state_nxt = pos_last ? ST_EMIT_RD : ST_WALK_RDO;
      ST_EMIT_RD:  state_nxt = ST_EMIT_LD;
      ST_EMIT_LD:  state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: if (out_fire) state_nxt = i_last ? ST_LOAD : ST_EMIT_RD;
      default:     state_nxt = ST_LOAD;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_fire && (count_r < CNT_W'(MAX_ITEMS))) begin
      item_mem[count_r[IDX_W-1:0]] <= {in_item_allowed, in_item_weight, in_item_value};
    end
    item_rd_r <= item_mem[item_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SORT_RD && used_r[i_r[IDX_W-1:0]] && i_last) begin
      order_mem[pos_r[IDX_W-1:0]] <= best_idx_r;
    end else if (state_r == ST_SORT_CMP && i_last) begin
      order_mem[pos_r[IDX_W-1:0]] <= (best_none_r || cmp_gt) ? i_r[IDX_W-1:0] : best_idx_r;
    end
    order_rd_r <= order_mem[pos_r[IDX_W-1:0]];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cap_r       <= '0;
      count_r     <= '0;
      n_r         <= '0;
      i_r         <= '0;
      pos_r       <= '0;
      used_r      <= '0;
      chosen_r    <= '0;
      best_none_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_knapsack_capacity;
      unique case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (in_last_item) begin
              n_r         <= (count_r < CNT_W'(MAX_ITEMS)) ? count_r + 1'b1 : count_r;
              count_r     <= '0;
              i_r         <= '0;
              pos_r       <= '0;
              used_r      <= '0;
              best_none_r <= 1'b1;
            end else if (count_r < CNT_W'(MAX_ITEMS)) begin
              count_r <= count_r + 1'b1;
            end
          end
        end
        ST_SORT_RD: begin
          if (used_r[i_r[IDX_W-1:0]]) begin
            if (i_last) begin
              used_r[best_idx_r] <= 1'b1;
              best_none_r        <= 1'b1;
              i_r                <= '0;
              pos_r              <= pos_last ? '0 : pos_r + 1'b1;
              if (pos_last) begin
                chosen_r <= '0;
                filled_r <= '0;
              end
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        ST_SORT_CMP: begin
          if (i_last) begin
            used_r[(best_none_r || cmp_gt) ? i_r[IDX_W-1:0] : best_idx_r] <= 1'b1;
            best_none_r <= 1'b1;
            i_r         <= '0;
            pos_r       <= pos_last ? '0 : pos_r + 1'b1;
            if (pos_last) begin
              chosen_r <= '0;
              filled_r <= '0;
            end
          end else begin
            i_r <= i_r + 1'b1;
            if (best_none_r || cmp_gt) begin
              best_none_r <= 1'b0;
              best_idx_r  <= i_r[IDX_W-1:0];
              best_v_r    <= rd_v;
              best_w_r    <= rd_w;
            end
          end
        end
        ST_WALK_RDI: k_r <= order_rd_r;
        ST_WALK_CHK: begin
          if (rd_a && fill_try <= {1'b0, cap_r}) begin
            chosen_r[k_r] <= 1'b1;
            filled_r      <= fill_try[CAP_W-1:0];
          end
          pos_r <= pos_r + 1'b1;
          if (pos_last) begin
            i_r     <= '0;
            sum_w_r <= '0;
            sum_v_r <= '0;
          end
        end
        ST_EMIT_LD: begin
          out_valid_r      <= 1'b1;
          out_item_index   <= i_r;
          out_item_chosen  <= chosen_r[i_r[IDX_W-1:0]];
          out_last_result  <= i_last;
          if (chosen_r[i_r[IDX_W-1:0]]) begin
            sum_w_r          <= sum_w_r + CAP_W'(rd_w);
            sum_v_r          <= sum_v_r + SUMV_W'(rd_v);
            out_total_weight <= sum_w_r + CAP_W'(rd_w);
            out_total_value  <= sum_v_r + SUMV_W'(rd_v);
          end else begin
            out_total_weight <= sum_w_r;
            out_total_value  <= sum_v_r;
          end
        end
        ST_EMIT_OUT: begin
          if (out_fire) begin
            out_valid_r <= 1'b0;
            i_r         <= i_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // a best candidate is always recorded when a pass closes
  // (the first unused item is always taken)
  `include "greedy_knapsack_selector_core_assert.svh"

  `GKS_ASSERT_SAME(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)
  `GKS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_ITEMS))
  `GKS_ASSERT_NEXT(a_last_ends_set, clk, rst_n, out_fire && out_last_result, in_ready)
  `GKS_ASSERT_SAME(a_fill_in_cap, clk, rst_n, state_r == ST_WALK_CHK, filled_r <= cap_r)
endmodule
`default_nettype wire

>>> tb/gks_selection_checker.sv
// ---------------------------------------------------------------------------
// gks_selection_checker
// Watches the capacity, item and result channels of the knapsack selector.
// It keeps its own item set and capacity, ranks each finished set by value
// density, walks it greedily and checks every result against the oldest
// expected one.
// ---------------------------------------------------------------------------
`default_nettype none
module gks_selection_checker import gks_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [CAP_W-1:0]  cfg_knapsack_capacity,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [VAL_W-1:0]  in_item_value,
  input  wire logic [WGT_W-1:0]  in_item_weight,
  input  wire logic              in_item_allowed,
  input  wire logic              in_last_item,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [IDX_W:0]    out_item_index,
  input  wire logic              out_item_chosen,
  input  wire logic [CAP_W-1:0]  out_total_weight,
  input  wire logic [SUMV_W-1:0] out_total_value,
  input  wire logic              out_last_result,
  output int                     fail_count,
  output int                     pending_count,
  output int                     result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W:0]    index;
    logic              chosen;
    logic [CAP_W-1:0]  weight_sum;
    logic [SUMV_W-1:0] value_sum;
    logic              last;
  } selection_t;

  logic [VAL_W-1:0] set_value [MAX_ITEMS];
  logic [WGT_W-1:0] set_weight [MAX_ITEMS];
  logic             set_allowed [MAX_ITEMS];
  int               set_size;
  logic [CAP_W-1:0] capacity;
  selection_t       expected_selections [$];

  // selection sort by descending density, ties to the lower index, then greedy fill
  task automatic solve_set();
    int rank [MAX_ITEMS];
    bit taken [MAX_ITEMS];
    bit chosen [MAX_ITEMS];
    int best;
    longint unsigned lhs, rhs, filled, wsum, vsum;
    selection_t sel;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      taken[i] = 0;
      chosen[i] = 0;
    end
    for (int p = 0; p < set_size; p++) begin
      best = -1;
      for (int i = 0; i < set_size; i++) begin
        if (!taken[i]) begin
          if (best < 0) begin
            best = i;
          end else begin
            lhs = longint'(set_value[i]) * longint'(set_weight[best]);
            rhs = longint'(set_value[best]) * longint'(set_weight[i]);
            if (lhs > rhs) best = i;
          end
        end
      end
      taken[best] = 1;
      rank[p] = best;
    end
    filled = 0;
    for (int p = 0; p < set_size; p++) begin
      if (set_allowed[rank[p]] && filled + set_weight[rank[p]] <= capacity) begin
        chosen[rank[p]] = 1;
        filled += set_weight[rank[p]];
      end
    end
    wsum = 0;
    vsum = 0;
    for (int i = 0; i < set_size; i++) begin
      if (chosen[i]) begin
        wsum += set_weight[i];
        vsum += set_value[i];
      end
      sel.index = (IDX_W+1)'(i);
      sel.chosen = chosen[i];
      sel.weight_sum = wsum[CAP_W-1:0];
      sel.value_sum = vsum[SUMV_W-1:0];
      sel.last = (i == set_size - 1);
      expected_selections.push_back(sel);
    end
    set_size = 0;
  endtask

  task automatic check_selection();
    selection_t want;
    result_count++;
    if (expected_selections.size() == 0) begin
      $display("%0t: unexpected result, index %0d", $time, out_item_index);
      fail_count++;
    end else begin
      want = expected_selections.pop_front();
      if (out_item_index !== want.index) begin
        $display("%0t: item_index expected %0d got %0d", $time, want.index, out_item_index);
        fail_count++;
      end
      if (out_item_chosen !== want.chosen) begin
        $display("%0t: item_chosen (index %0d) expected %0d got %0d",
                 $time, want.index, want.chosen, out_item_chosen);
        fail_count++;
      end
      if (out_total_weight !== want.weight_sum) begin
        $display("%0t: total_weight (index %0d) expected %0d got %0d",
                 $time, want.index, want.weight_sum, out_total_weight);
        fail_count++;
      end
      if (out_total_value !== want.value_sum) begin
        $display("%0t: total_value (index %0d) expected %0d got %0d",
                 $time, want.index, want.value_sum, out_total_value);
        fail_count++;
      end
      if (out_last_result !== want.last) begin
        $display("%0t: last_result (index %0d) expected %0d got %0d",
                 $time, want.index, want.last, out_last_result);
        fail_count++;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    result_count = 0;
    set_size = 0;
    capacity = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      set_size = 0;
      capacity = '0;
      expected_selections.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_knapsack_capacity;
      if (out_valid && out_ready) check_selection();
      if (in_valid && in_ready) begin
        // extras past a full set are dropped, but their last flag still counts
        if (set_size < MAX_ITEMS) begin
          set_value[set_size] = in_item_value;
          set_weight[set_size] = in_item_weight;
          set_allowed[set_size] = in_item_allowed;
          set_size++;
        end
        if (in_last_item) solve_set();
      end
    end
    pending_count = expected_selections.size();
  end
endmodule
`default_nettype wire

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the greedy knapsack selector.
// Sends item sets of varied size (single items, full sets, overlong sets)
// under several capacities, with random idling on both channels and long
// output hold-offs; a separate checker predicts and compares the results.
// ---------------------------------------------------------------------------
`default_nettype none
module tb;
  import gks_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 1000000;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_knapsack_capacity;
  logic              in_valid;
  logic              in_ready;
  logic [VAL_W-1:0]  in_item_value;
  logic [WGT_W-1:0]  in_item_weight;
  logic              in_item_allowed;
  logic              in_last_item;
  logic              out_valid;
  logic              out_ready;
  logic [IDX_W:0]    out_item_index;
  logic              out_item_chosen;
  logic [CAP_W-1:0]  out_total_weight;
  logic [SUMV_W-1:0] out_total_value;
  logic              out_last_result;
  int                fail_count;
  int                pending_count;
  int                result_count;
  int                cycle_count;
  int                items_sent;
  int                sets_sent;
  int                caps_written;
  bit                busy_phase;
  bit                long_hold;

  greedy_knapsack_selector_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_knapsack_capacity(cfg_knapsack_capacity),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_item_value(in_item_value), .in_item_weight(in_item_weight),
    .in_item_allowed(in_item_allowed), .in_last_item(in_last_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_item_index(out_item_index), .out_item_chosen(out_item_chosen),
    .out_total_weight(out_total_weight), .out_total_value(out_total_value),
    .out_last_result(out_last_result)
  );

  gks_selection_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_knapsack_capacity(cfg_knapsack_capacity),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_item_value(in_item_value), .in_item_weight(in_item_weight),
    .in_item_allowed(in_item_allowed), .in_last_item(in_last_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_item_index(out_item_index), .out_item_chosen(out_item_chosen),
    .out_total_weight(out_total_weight), .out_total_value(out_total_value),
    .out_last_result(out_last_result),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb NOT OK");
      $finish;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (busy_phase || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    out_ready = 0;
    hold = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (long_hold && out_valid) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else if (hold > 0) begin
        out_ready <= 0;
        hold--;
      end else begin
        out_ready <= 1;
        hold = idle_cycles();
      end
    end
  end

  task automatic send_item(input logic [VAL_W-1:0] v, input logic [WGT_W-1:0] w,
                           input logic a, input logic l);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_item_value <= v;
    in_item_weight <= w;
    in_item_allowed <= a;
    in_last_item <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (l) sets_sent++;
  endtask

  task automatic idle_inputs();
    @(posedge clk);
    in_valid <= 0;
  endtask

  // only while idle: every result in, then a short settle
  task automatic write_capacity(input logic [CAP_W-1:0] c);
    idle_inputs();
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_knapsack_capacity <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    caps_written++;
  endtask

  function automatic logic [15:0] rand_field();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom_range(1, 65535));
    if (r < 8) return 16'($urandom_range(1, 200));
    return (r == 8) ? 16'd1 : 16'hFFFF;
  endfunction

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++)
      send_item(rand_field(), rand_field(), $urandom_range(0, 4) != 0, i == n - 1);
  endtask

  initial begin
    int n, r;
    rst_n = 0;
    cfg_valid = 0;
    cfg_knapsack_capacity = '0;
    in_valid = 0;
    in_item_value = '0;
    in_item_weight = '0;
    in_item_allowed = 0;
    in_last_item = 0;
    cycle_count = 0;
    items_sent = 0;
    sets_sent = 0;
    caps_written = 0;
    busy_phase = 0;
    long_hold = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset capacity, nothing fits
    send_item(16'hFFFF, 16'hFFFF, 1, 1);
    write_capacity(24'hFFFFFF);
    send_item(16'hFFFF, 16'hFFFF, 1, 0);
    send_item(16'd1, 16'd1, 1, 0);
    send_item(16'd5, 16'd3, 0, 1);
    write_capacity(24'd10);
    // equal densities: lower index wins the tie
    send_item(16'd2, 16'd4, 1, 0);
    send_item(16'd1, 16'd2, 1, 0);
    send_item(16'd3, 16'd6, 1, 0);
    send_item(16'd9, 16'd3, 0, 0);
    send_item(16'd7, 16'd5, 1, 1);
    // overlong set, dropped items carry the last flag
    write_capacity(24'd70000);
    // results of this set are held off while the next set is offered
    long_hold = 1;
    send_random_set(MAX_ITEMS + 3);
    send_item(16'd40, 16'd10, 1, 0);
    for (int i = 0; i < MAX_ITEMS + 1; i++) send_item(16'd3, 16'd2, 1, 0);
    send_item(16'd50, 16'd1, 1, 1);

    // random phases
    while (items_sent < 300) begin
      r = $urandom_range(0, 5);
      if (r == 0) write_capacity('0);
      else if (r == 1) write_capacity(24'hFFFFFF);
      else write_capacity(CAP_W'($urandom_range(1, 300000)));
      busy_phase = ($urandom_range(0, 3) == 0);
      for (int s = 0; s < 4; s++) begin
        r = $urandom_range(0, 9);
        if (r == 0) n = MAX_ITEMS;
        else if (r == 1) n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
        else n = $urandom_range(1, 8);
        if (n >= MAX_ITEMS && caps_written > 6 && !long_hold && sets_sent < 40)
          long_hold = 1;
        send_random_set(n);
      end
      busy_phase = 0;
    end
    idle_inputs();
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d items in %0d sets, %0d results checked, %0d capacity writes",
             items_sent, sets_sent, result_count, caps_written);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
